// ===== hw/rtl/rcpe_pkg.sv =====
// Shared types and constants of the rotor cruise power estimator.
package rcpe_pkg;

  localparam logic [19:0] GRAVITY_Q16 = 20'd642908;
  localparam logic [16:0] RHO_MIN     = 17'd66;
  localparam logic [34:0] ETA_MIN     = 35'd4295;
  localparam logic [59:0] VH2_CAP     = {60{1'b1}};
  localparam logic [29:0] VI_CAP      = {30{1'b1}};
  localparam logic [31:0] SAT32       = 32'hFFFF_FFFF;
  localparam logic [21:0] SAT22       = 22'h3F_FFFF;

  localparam logic [16:0] FOM_RESET   = 17'd49152;
  localparam logic [16:0] MOTOR_RESET = 17'd58982;
  localparam logic [16:0] ESC_RESET   = 17'd62259;

  localparam logic [1:0] REG_FOM   = 2'd0;
  localparam logic [1:0] REG_MOTOR = 2'd1;
  localparam logic [1:0] REG_ESC   = 2'd2;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQRT,
    OP_DIV64,
    OP_DIV80
  } alu_op_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [79:0] a;
    logic [39:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } alu_rsp_t;

endpackage

// ===== hw/rtl/rcpe_in_if.sv =====
// Query channel: valid/ready handshake with the flight query fields.
interface rcpe_in_if import rcpe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [14:0]        airspeed;
  logic signed [13:0] climb_rate;
  logic [16:0]        air_density;
  logic [17:0]        vehicle_mass;
  logic [16:0]        drag_area;
  logic [19:0]        disk_area;

  modport source (output valid, airspeed, climb_rate, air_density, vehicle_mass,
                  drag_area, disk_area, input ready);
  modport sink (input valid, airspeed, climb_rate, air_density, vehicle_mass,
                drag_area, disk_area, output ready);
endinterface

// ===== hw/rtl/rcpe_out_if.sv =====
// Result channel: valid/ready handshake with thrust and power fields.
interface rcpe_out_if import rcpe_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [21:0] thrust_required;
  logic [31:0] induced_power;
  logic [31:0] parasite_power;
  logic [31:0] climb_power;
  logic [31:0] mechanical_power;
  logic [31:0] electrical_power;

  modport source (output valid, thrust_required, induced_power, parasite_power,
                  climb_power, mechanical_power, electrical_power, input ready);
  modport sink (input valid, thrust_required, induced_power, parasite_power,
                climb_power, mechanical_power, electrical_power, output ready);
endinterface

// ===== hw/rtl/rcpe_alu.sv =====
// Shared arithmetic unit: registered multiply, bit-serial divide and square root.
module rcpe_alu import rcpe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  alu_op_t     op_r;
  logic [6:0]  cnt_r;
  logic [79:0] sh_r;
  logic [40:0] rem_r;
  logic [63:0] quo_r;
  logic [39:0] den_r;

  logic [67:0] prod;
  logic [40:0] div_r2;
  logic        div_ge;
  logic [40:0] div_rem;
  logic [34:0] sq_r2;
  logic [34:0] sq_trial;
  logic        sq_ge;

  assign prod     = req.a[33:0] * req.b[33:0];
  assign div_r2   = {rem_r[39:0], sh_r[79]};
  assign div_ge   = div_r2 >= {1'b0, den_r};
  assign div_rem  = div_ge ? div_r2 - {1'b0, den_r} : div_r2;
  assign sq_r2    = {rem_r[32:0], sh_r[79:78]};
  assign sq_trial = {1'b0, quo_r[31:0], 2'b01};
  assign sq_ge    = sq_r2 >= sq_trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        case (req.op)
          OP_MUL: begin
            done_r <= 1'b1;
          end
          OP_SQRT: begin
            busy_r <= 1'b1;
            cnt_r  <= 7'd32;
          end
          OP_DIV64: begin
            busy_r <= 1'b1;
            cnt_r  <= 7'd64;
          end
          default: begin
            busy_r <= 1'b1;
            cnt_r  <= 7'd80;
          end
        endcase
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      rem_r <= '0;
      den_r <= req.b;
      case (req.op)
        OP_MUL: begin
          quo_r <= prod[63:0];
        end
        OP_DIV80: begin
          quo_r <= '0;
          sh_r  <= req.a;
        end
        default: begin
          quo_r <= '0;
          sh_r  <= {req.a[63:0], 16'd0};
        end
      endcase
    end else if (busy_r) begin
      if (op_r == OP_SQRT) begin
        // one root bit per cycle, two radicand bits in
        rem_r <= {6'd0, sq_ge ? sq_r2 - sq_trial : sq_r2};
        quo_r <= {quo_r[62:0], sq_ge};
        sh_r  <= {sh_r[77:0], 2'b00};
      end else begin
        rem_r <= div_rem;
        quo_r <= {quo_r[62:0], div_ge};
        sh_r  <= {sh_r[78:0], 1'b0};
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = quo_r;

endmodule

// ===== hw/rtl/rotor_cruise_power_estimator.sv =====
// Rotor cruise power estimator: weight, drag, thrust, induced velocity and powers.
//
// One flight query enters on in_ch; one result leaves on out_ch. A small sequencer
// drives a single shared arithmetic unit (registered 34x34 multiply, bit-serial
// restoring divide, bit-serial square root), so every product, root and quotient
// is one pass through that unit. The induced velocity is refined by at most
// NEWTON_STEPS Newton steps, stopping early once a step rounds to zero.
// in_ch.ready is high only while no query is in work. The result is held in an
// output register, so a new query is taken while an earlier result waits; a
// query that finishes while that register is still full waits until out_ch.ready.
// Configuration writes on cfg_* land at once and are meant for idle periods.
// Reset (rst_n low, synchronous) drops any query in work, empties the output
// register and loads the efficiency registers with their default fractions.
module rotor_cruise_power_estimator import rcpe_pkg::*; #(
  parameter int NEWTON_STEPS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  rcpe_in_if.sink      in_ch,
  rcpe_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_wdata
);

  localparam int KW = $clog2(NEWTON_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    P_W, P_VV2, P_Q, P_D, P_WW, P_DD, P_T, P_DEN, P_VH2, P_VH, P_VI0,
    P_UU, P_S, P_VIS, P_VIU, P_Q1, P_STEP,
    P_PI, P_PP, P_PC, P_E1, P_E2, P_EL
  } pc_t;

  state_t          state_r, state_nxt;
  pc_t             pc_r, pc_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic            out_valid_r;
  logic [16:0]     fom_r, motor_r, esc_r;

  // query operands
  logic [14:0]        v_r;
  logic signed [13:0] vv_r;
  logic [16:0]        rho_r;
  logic [17:0]        mass_r;
  logic [16:0]        area_r;
  logic [19:0]        disk_r;

  // intermediates
  logic [21:0]        w_r;
  logic [29:0]        v2_r;
  logic [29:0]        q_r;
  logic [22:0]        d_r;
  logic [63:0]        acc_r;
  logic [23:0]        t_r;
  logic [36:0]        den_r;
  logic [59:0]        vh2_r;
  logic [29:0]        vh_r;
  logic [29:0]        vi_r;
  logic [31:0]        s_r;
  logic signed [63:0] f_r;
  logic [60:0]        p_r;
  logic               pneg_r;
  logic signed [34:0] df_r;
  logic [41:0]        pi_r;
  logic [25:0]        pp_r;
  logic [22:0]        pc_r2;
  logic [33:0]        e_r;
  logic [34:0]        eta_r;
  logic [31:0]        elec_r;

  logic [21:0]        out_thrust_r;
  logic [31:0]        out_pi_r, out_pp_r, out_pc_r, out_mech_r, out_elec_r;

  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;
  logic [63:0]        res;
  logic               done_w;
  logic               accept;
  logic               load_out;

  logic signed [31:0] u_c;
  logic               uneg;
  logic [30:0]        mag;
  logic               fneg;
  logic [63:0]        fmag;
  logic [12:0]        vvpos;
  logic [42:0]        mech;
  logic [34:0]        eta_c;
  logic               v_gt_vh;
  logic               elec_sat;
  logic [63:0]        rnd12, rnd16, rnd17, rnd24;
  logic signed [34:0] q1s;
  logic signed [65:0] sm;
  logic signed [65:0] vi_new;
  logic [29:0]        vi_clamp;

  rcpe_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign res      = alu_rsp.result;
  assign done_w   = (state_r == ST_WAIT) && alu_rsp.done;
  assign accept   = in_ch.valid && in_ch.ready;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign u_c   = $signed({2'b00, vi_r}) + $signed({{18{vv_r[13]}}, vv_r});
  assign uneg  = u_c[31];
  assign mag   = uneg ? 31'(-u_c) : u_c[30:0];
  assign fneg  = f_r[63];
  assign fmag  = fneg ? 64'(-f_r) : 64'(f_r);
  assign vvpos = (vv_r > 14'sd0) ? vv_r[12:0] : 13'd0;
  assign mech  = 43'(pi_r) + 43'(pp_r) + 43'(pc_r2);
  assign eta_c = (res[50:16] < ETA_MIN) ? ETA_MIN : res[50:16];
  assign elec_sat = mech >= 43'(eta_c);
  assign v_gt_vh  = 30'(v_r) > res[29:0];

  assign rnd12 = res + 64'd2048;
  assign rnd16 = res + 64'd32768;
  assign rnd17 = res + 64'd65536;
  assign rnd24 = res + 64'd8388608;

  assign q1s    = $signed({4'd0, res[30:0]});
  assign sm     = $signed({2'b00, res});
  // Newton update, then fold back into range
  assign vi_new = fneg ? $signed({36'd0, vi_r}) + sm : $signed({36'd0, vi_r}) - sm;
  always_comb begin
    if (vi_new < 66'sd0) begin
      vi_clamp = {1'b0, vh_r[29:1]};
    end else if (vi_new > $signed({36'd0, VI_CAP})) begin
      vi_clamp = VI_CAP;
    end else begin
      vi_clamp = vi_new[29:0];
    end
  end

  // operands for the shared unit
  always_comb begin
    alu_req.start = (state_r == ST_ISSUE);
    alu_req.op    = OP_MUL;
    alu_req.a     = '0;
    alu_req.b     = '0;
    case (pc_r)
      P_W: begin
        alu_req.a = 80'(mass_r);
        alu_req.b = 40'(GRAVITY_Q16);
      end
      P_VV2: begin
        alu_req.a = 80'(v_r);
        alu_req.b = 40'(v_r);
      end
      P_Q: begin
        alu_req.a = 80'(rho_r);
        alu_req.b = 40'(v2_r);
      end
      P_D: begin
        alu_req.a = 80'(q_r);
        alu_req.b = 40'(area_r);
      end
      P_WW: begin
        alu_req.a = 80'(w_r);
        alu_req.b = 40'(w_r);
      end
      P_DD: begin
        alu_req.a = 80'(d_r);
        alu_req.b = 40'(d_r);
      end
      P_T: begin
        alu_req.op = OP_SQRT;
        alu_req.a  = 80'(acc_r);
      end
      P_DEN: begin
        alu_req.a = 80'(rho_r);
        alu_req.b = 40'(disk_r);
      end
      P_VH2: begin
        alu_req.op = OP_DIV64;
        alu_req.a  = 80'({t_r, 39'd0});
        alu_req.b  = 40'(den_r);
      end
      P_VH: begin
        alu_req.op = OP_SQRT;
        alu_req.a  = 80'(vh2_r);
      end
      P_VI0: begin
        alu_req.op = OP_DIV64;
        alu_req.a  = 80'(vh2_r);
        alu_req.b  = 40'(v_r);
      end
      P_UU: begin
        alu_req.a = 80'(mag);
        alu_req.b = 40'(mag);
      end
      P_S: begin
        alu_req.op = OP_SQRT;
        alu_req.a  = 80'(acc_r);
      end
      P_VIS: begin
        alu_req.a = 80'(vi_r);
        alu_req.b = 40'(s_r);
      end
      P_VIU: begin
        alu_req.a = 80'(vi_r);
        alu_req.b = 40'(mag);
      end
      P_Q1: begin
        alu_req.op = OP_DIV64;
        alu_req.a  = 80'(p_r);
        alu_req.b  = (s_r == 32'd0) ? 40'd1 : 40'(s_r);
      end
      P_STEP: begin
        alu_req.op = OP_DIV64;
        alu_req.a  = 80'(fmag);
        alu_req.b  = (df_r > 35'sd1) ? 40'(df_r[33:0]) : 40'd1;
      end
      P_PI: begin
        alu_req.a = 80'(t_r);
        alu_req.b = 40'(vi_r);
      end
      P_PP: begin
        alu_req.a = 80'(d_r);
        alu_req.b = 40'(v_r);
      end
      P_PC: begin
        alu_req.a = 80'(w_r);
        alu_req.b = 40'(vvpos);
      end
      P_E1: begin
        alu_req.a = 80'(fom_r);
        alu_req.b = 40'(motor_r);
      end
      P_E2: begin
        alu_req.a = 80'(e_r);
        alu_req.b = 40'(esc_r);
      end
      P_EL: begin
        alu_req.op = OP_DIV80;
        alu_req.a  = {5'd0, mech, 32'd0};
        alu_req.b  = 40'(eta_r);
      end
      default: begin
        alu_req.op = OP_MUL;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_ISSUE;
          pc_nxt    = P_W;
          k_nxt     = '0;
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (alu_rsp.done) begin
          state_nxt = ST_ISSUE;
          case (pc_r)
            P_W:    pc_nxt = P_VV2;
            P_VV2:  pc_nxt = P_Q;
            P_Q:    pc_nxt = P_D;
            P_D:    pc_nxt = P_WW;
            P_WW:   pc_nxt = P_DD;
            P_DD:   pc_nxt = P_T;
            P_T:    pc_nxt = P_DEN;
            P_DEN:  pc_nxt = P_VH2;
            P_VH2:  pc_nxt = P_VH;
            P_VH:   pc_nxt = v_gt_vh ? P_VI0 : P_UU;
            P_VI0:  pc_nxt = P_UU;
            P_UU:   pc_nxt = P_S;
            P_S:    pc_nxt = P_VIS;
            P_VIS:  pc_nxt = P_VIU;
            P_VIU:  pc_nxt = P_Q1;
            P_Q1:   pc_nxt = P_STEP;
            P_STEP: begin
              // stop on a zero step or when the step budget is spent
              if (res == 64'd0 || k_r == KW'(NEWTON_STEPS - 1)) begin
                pc_nxt = P_PI;
              end else begin
                pc_nxt = P_UU;
                k_nxt  = k_r + 1'b1;
              end
            end
            P_PI:   pc_nxt = P_PP;
            P_PP:   pc_nxt = P_PC;
            P_PC:   pc_nxt = P_E1;
            P_E1:   pc_nxt = P_E2;
            P_E2: begin
              if (elec_sat) begin
                state_nxt = ST_DONE;
              end else begin
                pc_nxt = P_EL;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      default: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= P_W;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      fom_r       <= FOM_RESET;
      motor_r     <= MOTOR_RESET;
      esc_r       <= ESC_RESET;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      k_r     <= k_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FOM:   fom_r   <= cfg_wdata;
          REG_MOTOR: motor_r <= cfg_wdata;
          REG_ESC:   esc_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      v_r    <= in_ch.airspeed;
      vv_r   <= in_ch.climb_rate;
      rho_r  <= (in_ch.air_density < RHO_MIN) ? RHO_MIN : in_ch.air_density;
      mass_r <= in_ch.vehicle_mass;
      area_r <= in_ch.drag_area;
      disk_r <= (in_ch.disk_area == 20'd0) ? 20'd1 : in_ch.disk_area;
    end
    if (done_w) begin
      case (pc_r)
        P_W:    w_r   <= rnd16[37:16];
        P_VV2:  v2_r  <= res[29:0];
        P_Q:    q_r   <= rnd17[46:17];
        P_D:    d_r   <= rnd24[46:24];
        P_WW:   acc_r <= res;
        P_DD:   acc_r <= acc_r + res;
        P_T:    t_r   <= res[23:0];
        P_DEN:  den_r <= res[36:0];
        P_VH2:  vh2_r <= (res > 64'(VH2_CAP)) ? VH2_CAP : res[59:0];
        P_VH: begin
          vh_r <= res[29:0];
          if (!v_gt_vh) begin
            vi_r <= res[29:0];
          end
        end
        P_VI0:  vi_r  <= res[29:0];
        P_UU:   acc_r <= res + 64'(v2_r);
        P_S:    s_r   <= res[31:0];
        P_VIS:  f_r   <= $signed(res) - $signed({4'd0, vh2_r});
        P_VIU: begin
          p_r    <= res[60:0];
          pneg_r <= uneg;
        end
        P_Q1:   df_r  <= $signed({3'd0, s_r}) + (pneg_r ? -q1s : q1s);
        P_STEP: vi_r  <= vi_clamp;
        P_PI:   pi_r  <= rnd12[53:12];
        P_PP:   pp_r  <= rnd12[37:12];
        P_PC:   pc_r2 <= rnd12[34:12];
        P_E1:   e_r   <= res[33:0];
        P_E2: begin
          eta_r <= eta_c;
          if (elec_sat) begin
            elec_r <= SAT32;
          end
        end
        P_EL:   elec_r <= res[31:0];
        default: ;
      endcase
    end
    if (load_out) begin
      out_thrust_r <= (t_r > 24'(SAT22)) ? SAT22 : t_r[21:0];
      out_pi_r     <= (pi_r > 42'(SAT32)) ? SAT32 : pi_r[31:0];
      out_pp_r     <= 32'(pp_r);
      out_pc_r     <= 32'(pc_r2);
      out_mech_r   <= (mech > 43'(SAT32)) ? SAT32 : mech[31:0];
      out_elec_r   <= elec_r;
    end
  end

  assign in_ch.ready             = (state_r == ST_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.thrust_required  = out_thrust_r;
  assign out_ch.induced_power    = out_pi_r;
  assign out_ch.parasite_power   = out_pp_r;
  assign out_ch.climb_power      = out_pc_r;
  assign out_ch.mechanical_power = out_mech_r;
  assign out_ch.electrical_power = out_elec_r;

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_ISSUE && pc_r == P_W))
    else $error("query accepted but sequence did not start");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result shown without a finished query");

  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (k_r <= KW'(NEWTON_STEPS - 1)))
    else $error("Newton step count beyond budget");

  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !alu_rsp.done)
    else $error("arithmetic unit finished while no query in work");

endmodule
